// ===== design/glo_pkg.sv =====
// Shared types and constants of the grid line overlay.
// Holds payload structs, config struct, register map codes and the
// controller/datapath command and status bundles. No dependencies.
package glo_pkg;

  localparam int MAX_DIM   = 4096;
  localparam int SIZE_W    = $clog2(MAX_DIM + 1);
  localparam int POS_W     = $clog2(MAX_DIM);

  localparam int CFG_DIM_W = 13;
  localparam int PARTS_W   = 13;
  localparam int THICK_W   = 8;
  localparam int COLOR_W   = 24;
  localparam int CH_W      = 8;

  localparam int DVD_W     = POS_W + PARTS_W;
  localparam int DVS_W     = (SIZE_W > PARTS_W) ? SIZE_W : PARTS_W;

  localparam int ADDR_W    = 5;
  localparam int DATA_W    = 32;
  localparam int IDX_W     = ADDR_W - 2;

  localparam logic [IDX_W-1:0] REG_FRAME_WIDTH    = IDX_W'(0);
  localparam logic [IDX_W-1:0] REG_FRAME_HEIGHT   = IDX_W'(1);
  localparam logic [IDX_W-1:0] REG_ROW_PARTS      = IDX_W'(2);
  localparam logic [IDX_W-1:0] REG_COLUMN_PARTS   = IDX_W'(3);
  localparam logic [IDX_W-1:0] REG_LINE_THICKNESS = IDX_W'(4);
  localparam logic [IDX_W-1:0] REG_LINE_COLOR     = IDX_W'(5);

  localparam logic [CFG_DIM_W-1:0] RST_FRAME_WIDTH    = CFG_DIM_W'(640);
  localparam logic [CFG_DIM_W-1:0] RST_FRAME_HEIGHT   = CFG_DIM_W'(480);
  localparam logic [PARTS_W-1:0]   RST_ROW_PARTS      = PARTS_W'(1);
  localparam logic [PARTS_W-1:0]   RST_COLUMN_PARTS   = PARTS_W'(1);
  localparam logic [THICK_W-1:0]   RST_LINE_THICKNESS = THICK_W'(1);
  localparam logic [COLOR_W-1:0]   RST_LINE_COLOR     = '0;

  localparam logic AXIS_ROW     = 1'b0;
  localparam logic AXIS_COL     = 1'b1;
  localparam logic DIV_BY_SIZE  = 1'b0;
  localparam logic DIV_BY_PARTS = 1'b1;

  typedef struct packed {
    logic [CH_W-1:0] red_in;
    logic [CH_W-1:0] green_in;
    logic [CH_W-1:0] blue_in;
  } pix_in_t;

  typedef struct packed {
    logic [CH_W-1:0] red_out;
    logic [CH_W-1:0] green_out;
    logic [CH_W-1:0] blue_out;
    logic            end_of_frame;
  } pix_out_t;

  typedef struct packed {
    logic [CFG_DIM_W-1:0] frame_width;
    logic [CFG_DIM_W-1:0] frame_height;
    logic [PARTS_W-1:0]   row_parts;
    logic [PARTS_W-1:0]   column_parts;
    logic [THICK_W-1:0]   line_thickness;
    logic [COLOR_W-1:0]   line_color;
  } cfg_t;

  typedef struct packed {
    logic accept;
    logic axis;
    logic mul1;
    logic mul2;
    logic div_start;
    logic div_sel;
    logic band_wr;
    logic band_val;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic col_zero;
    logic trivial;
    logic n_over;
    logic div_done;
    logic hit;
    logic out_free;
  } sts_t;

endpackage

// ===== design/glo_regs.sv =====
// Configuration register file with an APB-style slave port.
// Depends on glo_pkg for the register map, reset values and cfg_t.
module glo_regs import glo_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  cfg_t             regs;
  logic [IDX_W-1:0] idx;
  logic             wr;

  assign idx    = paddr[ADDR_W-1:2];
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = regs;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.frame_width    <= RST_FRAME_WIDTH;
      regs.frame_height   <= RST_FRAME_HEIGHT;
      regs.row_parts      <= RST_ROW_PARTS;
      regs.column_parts   <= RST_COLUMN_PARTS;
      regs.line_thickness <= RST_LINE_THICKNESS;
      regs.line_color     <= RST_LINE_COLOR;
    end else if (wr) begin
      unique case (idx)
        REG_FRAME_WIDTH:    regs.frame_width    <= pwdata[CFG_DIM_W-1:0];
        REG_FRAME_HEIGHT:   regs.frame_height   <= pwdata[CFG_DIM_W-1:0];
        REG_ROW_PARTS:      regs.row_parts      <= pwdata[PARTS_W-1:0];
        REG_COLUMN_PARTS:   regs.column_parts   <= pwdata[PARTS_W-1:0];
        REG_LINE_THICKNESS: regs.line_thickness <= pwdata[THICK_W-1:0];
        REG_LINE_COLOR:     regs.line_color     <= pwdata[COLOR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_FRAME_WIDTH:    prdata = DATA_W'(regs.frame_width);
      REG_FRAME_HEIGHT:   prdata = DATA_W'(regs.frame_height);
      REG_ROW_PARTS:      prdata = DATA_W'(regs.row_parts);
      REG_COLUMN_PARTS:   prdata = DATA_W'(regs.column_parts);
      REG_LINE_THICKNESS: prdata = DATA_W'(regs.line_thickness);
      REG_LINE_COLOR:     prdata = DATA_W'(regs.line_color);
      default:            prdata = '0;
    endcase
  end

endmodule

// ===== design/glo_div.sv =====
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on glo_pkg for the dividend and divisor widths.
module glo_div import glo_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             busy,
  output logic             done,
  output logic [DVD_W-1:0] quotient
);

  localparam int CNT_W = $clog2(DVD_W);

  logic [DVS_W-1:0] rem;
  logic [DVS_W-1:0] dvs;
  logic [DVD_W-1:0] quo;
  logic [CNT_W-1:0] cnt;
  logic [DVS_W:0]   trial;
  logic [DVS_W:0]   diff;
  logic             ge;

  assign trial    = {rem, quo[DVD_W-1]};
  assign ge       = trial >= {1'b0, dvs};
  assign diff     = trial - {1'b0, dvs};
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(DVD_W - 1);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      rem <= ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
      quo <= {quo[DVD_W-2:0], ge};
    end
  end

endmodule

// ===== design/glo_dpath.sv =====
// Datapath: row/column counters, band test operands, shared divider,
// band flags and the output register. Depends on glo_pkg and glo_div.
module glo_dpath import glo_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  cfg_t     cfg,
  input  cmd_t     cmd,
  output sts_t     sts,
  input  pix_in_t  pixel,
  output logic     result_valid,
  input  logic     result_stall,
  output pix_out_t result
);

  function automatic logic [SIZE_W-1:0] eff_dim(input logic [CFG_DIM_W-1:0] v);
    logic [31:0] wide;
    wide = 32'(v);
    if (wide == 32'd0) begin
      eff_dim = SIZE_W'(1);
    end else if (wide > 32'(MAX_DIM)) begin
      eff_dim = SIZE_W'(MAX_DIM);
    end else begin
      eff_dim = SIZE_W'(wide);
    end
  endfunction

  logic [SIZE_W-1:0]  w_eff;
  logic [SIZE_W-1:0]  h_eff;
  logic [POS_W-1:0]   row_pos;
  logic [POS_W-1:0]   col_pos;
  logic [POS_W-1:0]   row_l;
  logic [POS_W-1:0]   col_l;
  pix_in_t            item;
  logic               eof_l;
  logic               row_end;
  logic               frame_end;
  logic               row_on_line;
  logic               col_hit;
  logic [DVD_W-1:0]   prod;

  logic [POS_W-1:0]   p;
  logic [SIZE_W-1:0]  size;
  logic [PARTS_W-1:0] parts;
  logic [THICK_W-1:0] t;
  logic [THICK_W-1:0] lead;
  logic [THICK_W-1:0] after;
  logic [POS_W-1:0]   lo;
  logic [DVD_W-1:0]   nclamp;
  logic [DVD_W-1:0]   dvd;
  logic [DVS_W-1:0]   dvs;
  logic [DVD_W-1:0]   quo;
  logic               div_busy;
  logic               div_done;
  logic               draw;
  logic               out_free;

  assign w_eff = eff_dim(cfg.frame_width);
  assign h_eff = eff_dim(cfg.frame_height);

  assign row_end   = (SIZE_W'(col_pos) + 1'b1) >= w_eff;
  assign frame_end = row_end && ((SIZE_W'(row_pos) + 1'b1) >= h_eff);

  always_ff @(posedge clk) begin
    if (rst) begin
      row_pos <= '0;
      col_pos <= '0;
    end else if (cmd.accept) begin
      if (row_end) begin
        col_pos <= '0;
        row_pos <= frame_end ? '0 : row_pos + 1'b1;
      end else begin
        col_pos <= col_pos + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      item  <= pixel;
      row_l <= row_pos;
      col_l <= col_pos;
      eof_l <= frame_end;
    end
  end

  assign p      = (cmd.axis == AXIS_COL) ? col_l : row_l;
  assign size   = (cmd.axis == AXIS_COL) ? w_eff : h_eff;
  assign parts  = (cmd.axis == AXIS_COL) ? cfg.column_parts : cfg.row_parts;
  assign t      = cfg.line_thickness;
  assign lead   = (t - 1'b1) >> 1;
  assign after  = t >> 1;
  assign lo     = (p >= POS_W'(after)) ? p - POS_W'(after) : '0;
  assign nclamp = (quo == '0) ? DVD_W'(1) : quo;

  always_ff @(posedge clk) begin
    if (cmd.mul1) begin
      prod <= DVD_W'(lo) * DVD_W'(parts);
    end else if (cmd.mul2) begin
      prod <= DVD_W'(nclamp[PARTS_W-1:0]) * DVD_W'(size);
    end
  end

  assign dvd = (cmd.div_sel == DIV_BY_SIZE) ? prod + DVD_W'(size) - 1'b1 : prod;
  assign dvs = (cmd.div_sel == DIV_BY_SIZE) ? DVS_W'(size) : DVS_W'(parts);

  glo_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (dvd),
    .divisor  (dvs),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (quo)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      row_on_line <= 1'b0;
    end else if (cmd.band_wr && cmd.axis == AXIS_ROW) begin
      row_on_line <= cmd.band_val;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.band_wr && cmd.axis == AXIS_COL) begin
      col_hit <= cmd.band_val;
    end
  end

  assign draw     = row_on_line || col_hit;
  assign out_free = !result_valid || !result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.out_load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      result.red_out      <= draw ? cfg.line_color[23:16] : item.red_in;
      result.green_out    <= draw ? cfg.line_color[15:8]  : item.green_in;
      result.blue_out     <= draw ? cfg.line_color[7:0]   : item.blue_in;
      result.end_of_frame <= eof_l;
    end
  end

  assign sts.col_zero = (col_pos == '0);
  assign sts.trivial  = (t == '0) || (parts < PARTS_W'(2));
  assign sts.n_over   = nclamp > (DVD_W'(parts) - 1'b1);
  assign sts.div_done = div_done;
  assign sts.hit      = quo <= (DVD_W'(p) + DVD_W'(lead));
  assign sts.out_free = out_free;

  a_div_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.div_start |-> !div_busy)
    else $error("divider started while busy");

  a_out_room: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> out_free)
    else $error("output register overwritten");

  a_row_at_start: assert property (@(posedge clk) disable iff (rst)
    (cmd.band_wr && cmd.axis == AXIS_ROW) |-> col_l == '0)
    else $error("row band updated away from row start");

  a_n_range: assert property (@(posedge clk) disable iff (rst)
    cmd.mul2 |-> !sts.n_over)
    else $error("band index out of range reached centre step");

endmodule

// ===== design/glo_ctrl.sv =====
// Controller state machine: sequences the band tests of one pixel
// through the datapath. Depends on glo_pkg for cmd_t and sts_t.
module glo_ctrl import glo_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic pixel_valid,
  output logic pixel_stall,
  input  sts_t sts,
  output cmd_t cmd
);

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_MUL1   = 4'd1;
  localparam logic [3:0] ST_DIV1GO = 4'd2;
  localparam logic [3:0] ST_DIV1   = 4'd3;
  localparam logic [3:0] ST_MUL2   = 4'd4;
  localparam logic [3:0] ST_DIV2GO = 4'd5;
  localparam logic [3:0] ST_DIV2   = 4'd6;
  localparam logic [3:0] ST_CMP    = 4'd7;
  localparam logic [3:0] ST_OUT    = 4'd8;

  logic [3:0] state;
  logic [3:0] state_next;
  logic       axis;
  logic       axis_next;
  logic [3:0] done_state;
  logic       done_axis;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      axis  <= AXIS_ROW;
    end else begin
      state <= state_next;
      axis  <= axis_next;
    end
  end

  assign pixel_stall = (state != ST_IDLE);

  // after a band test: row test goes on to the column test, column test to the output
  assign done_state = (axis == AXIS_ROW) ? ST_MUL1 : ST_OUT;
  assign done_axis  = AXIS_COL;

  always_comb begin
    state_next    = state;
    axis_next     = axis;
    cmd           = '0;
    cmd.axis      = axis;
    unique case (state)
      ST_IDLE: begin
        if (pixel_valid) begin
          cmd.accept = 1'b1;
          axis_next  = sts.col_zero ? AXIS_ROW : AXIS_COL;
          state_next = ST_MUL1;
        end
      end
      ST_MUL1: begin
        if (sts.trivial) begin
          cmd.band_wr  = 1'b1;
          cmd.band_val = 1'b0;
          axis_next    = done_axis;
          state_next   = done_state;
        end else begin
          cmd.mul1   = 1'b1;
          state_next = ST_DIV1GO;
        end
      end
      ST_DIV1GO: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_BY_SIZE;
        state_next    = ST_DIV1;
      end
      ST_DIV1: begin
        if (sts.div_done) begin
          state_next = ST_MUL2;
        end
      end
      ST_MUL2: begin
        if (sts.n_over) begin
          cmd.band_wr  = 1'b1;
          cmd.band_val = 1'b0;
          axis_next    = done_axis;
          state_next   = done_state;
        end else begin
          cmd.mul2   = 1'b1;
          state_next = ST_DIV2GO;
        end
      end
      ST_DIV2GO: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_BY_PARTS;
        state_next    = ST_DIV2;
      end
      ST_DIV2: begin
        if (sts.div_done) begin
          state_next = ST_CMP;
        end
      end
      ST_CMP: begin
        cmd.band_wr  = 1'b1;
        cmd.band_val = sts.hit;
        axis_next    = done_axis;
        state_next   = done_state;
      end
      ST_OUT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== design/grid_line_overlay_top.sv =====
// Grid line overlay on a 24-bit RGB pixel stream.
// Pixels enter on the pixel channel (valid/stall) in raster order; each
// yields one transfer on the result channel, either the pixel unchanged
// or the line color, with end_of_frame set on the last pixel of a frame.
// Row and column are counted internally from frame_width/frame_height.
// Registers must be written through the APB-style port only between
// pixels; the block itself does not enforce this. One pixel is in work
// at a time. A band test runs two divisions on a shared bit-serial
// divider and is skipped when no lines are drawn; the row test runs
// only on the first pixel of a row.
// The result sits in an output register: the next pixel is taken while
// it waits, and a stalled result holds until transferred, blocking only
// the pixel after that.
// Reset restores the register defaults, clears the counters and row band
// flag, and empties the output register.
// Depends on glo_pkg, glo_regs, glo_ctrl, glo_dpath.
module grid_line_overlay_top import glo_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              pixel_valid,
  output logic              pixel_stall,
  input  pix_in_t           pixel,
  output logic              result_valid,
  input  logic              result_stall,
  output pix_out_t          result,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  cfg_t cfg;
  cmd_t cmd;
  sts_t sts;

  glo_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  glo_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .pixel_valid (pixel_valid),
    .pixel_stall (pixel_stall),
    .sts         (sts),
    .cmd         (cmd)
  );

  glo_dpath u_dpath (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .cmd          (cmd),
    .sts          (sts),
    .pixel        (pixel),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule

// ===== dv/tb_grid_line_overlay_top.sv =====
`timescale 1ns / 1ps
// Self-checking bench for grid_line_overlay_top: predicts each overlaid pixel
// from a shadow of the registers and raster counters, checks results in order.
// Depends on glo_pkg and the grid_line_overlay_top RTL.
module tb_grid_line_overlay_top;
  import glo_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned HOLD_LEN    = 600;
  localparam int unsigned DRAIN_WAIT  = 150;
  localparam int unsigned PHASES      = 32;
  localparam int unsigned PHASE_ITEMS = 50;

  logic              clk;
  logic              rst = 1'b1;
  logic              pixel_valid = 1'b0;
  logic              pixel_stall;
  pix_in_t           pixel = '0;
  logic              result_valid;
  logic              result_stall = 1'b0;
  pix_out_t          result;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  grid_line_overlay_top u_dut (
    .clk          (clk),
    .rst          (rst),
    .pixel_valid  (pixel_valid),
    .pixel_stall  (pixel_stall),
    .pixel        (pixel),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  pix_in_t     pixel_backlog[$];
  pix_out_t    expected_pixels[$];
  cfg_t        regs = '{RST_FRAME_WIDTH, RST_FRAME_HEIGHT, RST_ROW_PARTS,
                        RST_COLUMN_PARTS, RST_LINE_THICKNESS, RST_LINE_COLOR};
  int unsigned row_pos = 0;
  int unsigned col_pos = 0;
  bit          row_band = 1'b0;

  int unsigned pushed_count = 0;
  int unsigned accepted_count = 0;
  int unsigned checked_count = 0;
  int unsigned line_pixels = 0;
  int unsigned frame_ends = 0;
  int unsigned settings_used = 0;
  int unsigned fail_count = 0;
  int unsigned cycle_count = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_left = 0;
  logic        hold_trigger = 1'b0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic int unsigned clamp_dim(int unsigned v);
    if (v == 0) return 1;
    if (v > MAX_DIM) return MAX_DIM;
    return v;
  endfunction

  function automatic bit band_hit(int unsigned p, int unsigned size,
                                  int unsigned parts, int unsigned t);
    longint unsigned lead, trail, lo, n, centre;
    if (t == 0 || parts < 2) return 1'b0;
    lead  = (t - 1) / 2;
    trail = t / 2;
    lo    = (p >= trail) ? p - trail : 0;
    n     = (lo * parts + size - 1) / size;
    if (n < 1) n = 1;
    if (n > parts - 1) return 1'b0;
    centre = n * size / parts;
    return centre <= p + lead;
  endfunction

  function automatic void overlay_pixel(pix_in_t px);
    int unsigned w, h;
    bit          draw, row_end, frame_end;
    pix_out_t    want;
    w = clamp_dim(regs.frame_width);
    h = clamp_dim(regs.frame_height);
    if (col_pos == 0) row_band = band_hit(row_pos, h, regs.row_parts, regs.line_thickness);
    draw = row_band || band_hit(col_pos, w, regs.column_parts, regs.line_thickness);
    if (draw) begin
      {want.red_out, want.green_out, want.blue_out} = regs.line_color;
      line_pixels++;
    end else begin
      {want.red_out, want.green_out, want.blue_out} = px;
    end
    row_end   = (col_pos + 1 >= w);
    frame_end = row_end && (row_pos + 1 >= h);
    want.end_of_frame = frame_end;
    expected_pixels.push_back(want);
    if (frame_end) frame_ends++;
    if (row_end) begin
      col_pos = 0;
      row_pos = frame_end ? 0 : row_pos + 1;
    end else begin
      col_pos = col_pos + 1;
    end
  endfunction

  function automatic void flag_failure(string why);
    fail_count++;
    if (fail_count <= 10) $display("mismatch at %0t: %s", $time, why);
  endfunction

  function automatic void check_result(pix_out_t got);
    pix_out_t want;
    if (expected_pixels.size() == 0) begin
      flag_failure($sformatf("unexpected transfer r=%h g=%h b=%h eof=%b",
                             got.red_out, got.green_out, got.blue_out, got.end_of_frame));
      return;
    end
    want = expected_pixels.pop_front();
    if (got.red_out !== want.red_out || got.green_out !== want.green_out ||
        got.blue_out !== want.blue_out || got.end_of_frame !== want.end_of_frame)
      flag_failure($sformatf("result %0d want r=%h g=%h b=%h eof=%b, got r=%h g=%h b=%h eof=%b",
                             checked_count, want.red_out, want.green_out, want.blue_out,
                             want.end_of_frame, got.red_out, got.green_out, got.blue_out,
                             got.end_of_frame));
    checked_count++;
  endfunction

  // pixel driver
  always @(posedge clk) begin
    if (rst) begin
      pixel_valid <= 1'b0;
    end else begin
      if (pixel_valid && !pixel_stall) begin
        overlay_pixel(pixel);
        accepted_count++;
      end
      if (!pixel_valid || !pixel_stall) begin
        if (pixel_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          pixel       <= pixel_backlog.pop_front();
          pixel_valid <= 1'b1;
        end else begin
          pixel_valid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
    end else if (hold_trigger) begin
      hold_left <= HOLD_LEN;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
    end else begin
      if (result_valid && !result_stall) check_result(result);
      result_stall <= (hold_left != 0) || ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, expected_pixels.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic reg_write(input logic [IDX_W-1:0] idx, input int unsigned value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_FRAME_WIDTH:    regs.frame_width    = CFG_DIM_W'(value);
      REG_FRAME_HEIGHT:   regs.frame_height   = CFG_DIM_W'(value);
      REG_ROW_PARTS:      regs.row_parts      = PARTS_W'(value);
      REG_COLUMN_PARTS:   regs.column_parts   = PARTS_W'(value);
      REG_LINE_THICKNESS: regs.line_thickness = THICK_W'(value);
      REG_LINE_COLOR:     regs.line_color     = COLOR_W'(value);
      default: ;
    endcase
  endtask

  task automatic apply_setting(input int unsigned w, input int unsigned h,
                               input int unsigned rp, input int unsigned cp,
                               input int unsigned t, input int unsigned color);
    reg_write(REG_FRAME_WIDTH, w);
    reg_write(REG_FRAME_HEIGHT, h);
    reg_write(REG_ROW_PARTS, rp);
    reg_write(REG_COLUMN_PARTS, cp);
    reg_write(REG_LINE_THICKNESS, t);
    reg_write(REG_LINE_COLOR, color);
    settings_used++;
  endtask

  function automatic int unsigned pick_dim(int unsigned usual);
    if ($urandom_range(9) != 0) return $urandom_range(usual, 1);
    case ($urandom_range(3))
      0:       return 0;
      1:       return MAX_DIM;
      2:       return $urandom_range(8191, MAX_DIM + 1);
      default: return $urandom_range(MAX_DIM - 1, 1);
    endcase
  endfunction

  function automatic int unsigned pick_parts(int unsigned dim);
    case ($urandom_range(7))
      0:       return 0;
      1:       return 1;
      2:       return $urandom_range(8191);
      default: return $urandom_range((dim > 20 ? 20 : dim) + 3, 2);
    endcase
  endfunction

  function automatic int unsigned pick_thickness();
    case ($urandom_range(7))
      0:       return 0;
      1:       return 255;
      2:       return $urandom_range(255);
      default: return $urandom_range(5, 1);
    endcase
  endfunction

  task automatic random_setting();
    int unsigned w, h;
    w = pick_dim(24);
    h = pick_dim(10);
    apply_setting(w, h, pick_parts(h), pick_parts(w), pick_thickness(),
                  $urandom_range(24'hFFFFFF));
  endtask

  function automatic void queue_pixel(pix_in_t px);
    pixel_backlog.push_back(px);
    pushed_count++;
  endfunction

  function automatic pix_in_t rand_pixel();
    pix_in_t px;
    px.red_in   = $urandom_range(255);
    px.green_in = $urandom_range(255);
    px.blue_in  = $urandom_range(255);
    return px;
  endfunction

  function automatic pix_in_t corner_pixel(int unsigned k);
    case (k % 5)
      0:       return '{8'h00, 8'h00, 8'h00};
      1:       return '{8'hFF, 8'hFF, 8'hFF};
      2:       return '{8'hAA, 8'h55, 8'hAA};
      3:       return '{8'h55, 8'hAA, 8'h55};
      default: return rand_pixel();
    endcase
  endfunction

  task automatic wait_idle();
    while (accepted_count != pushed_count || expected_pixels.size() != 0) @(posedge clk);
  endtask

  task automatic send_corner(input int unsigned count);
    for (int unsigned k = 0; k < count; k++) queue_pixel(corner_pixel(k));
    wait_idle();
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // register defaults, then extremes of every register
    send_corner(2);
    apply_setting(4, 3, 3, 2, 1, 24'h123456);
    send_corner(12);
    apply_setting(0, 0, 0, MAX_DIM, 255, 24'hFFFFFF);
    send_corner(3);
    apply_setting(8191, 8191, MAX_DIM, MAX_DIM, 0, 24'h000000);
    send_corner(3);
    apply_setting(MAX_DIM, MAX_DIM, 2, 2, 2, 24'hA5A5A5);
    send_corner(3);

    for (int unsigned ph = 0; ph < PHASES; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 71; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 71; end
        default: begin send_idle_pct = 37; recv_stall_pct = 37; end
      endcase
      random_setting();
      for (int unsigned k = 0; k < PHASE_ITEMS; k++) queue_pixel(rand_pixel());
      if (ph % 16 == 4) begin
        hold_trigger <= 1'b1;
        @(posedge clk);
        hold_trigger <= 1'b0;
      end
      wait_idle();
    end

    repeat (DRAIN_WAIT) @(posedge clk);
    $display("checked %0d pixels over %0d register settings", checked_count, settings_used);
    $display("%0d pixels took the line color, %0d frame ends seen", line_pixels, frame_ends);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/glo_pkg.sv
design/glo_regs.sv
design/glo_div.sv
design/glo_dpath.sv
design/glo_ctrl.sv
design/grid_line_overlay_top.sv
dv/tb_grid_line_overlay_top.sv
